// ----- src/ssort_pkg.sv -----
package ssort_pkg;

	localparam int DEPTH     = 64;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int GAP_COUNT = 8;
	localparam int GAP_SEL_W = $clog2(GAP_COUNT) + 1;
	localparam int GAP_W     = 10;
	localparam int VAL_W     = 32;
	localparam int TALLY_W   = 16;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} ssort_in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    final_res;
		logic [TALLY_W-1:0]      compare_count;
		logic [TALLY_W-1:0]      shift_count;
	} ssort_out_t;

	// Ciura gap sequence, largest first
	function automatic logic [GAP_W-1:0] gap_at(input logic [GAP_SEL_W-2:0] sel);
		logic [GAP_W-1:0] g;
		case (sel)
			3'd0: g = 10'd701;
			3'd1: g = 10'd301;
			3'd2: g = 10'd132;
			3'd3: g = 10'd57;
			3'd4: g = 10'd23;
			3'd5: g = 10'd10;
			3'd6: g = 10'd4;
			3'd7: g = 10'd1;
			default: g = 10'd1;
		endcase
		return g;
	endfunction

	function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] c);
		logic [TALLY_W-1:0] r;
		r = (c == {TALLY_W{1'b1}}) ? c : c + 1'b1;
		return r;
	endfunction

endpackage

// ----- src/ssort_ram.sv -----
module ssort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/shell_sort_engine.sv -----
// Load: one element per cycle, item_ready high while collecting.
// Sort: each table gap below the element count in turn; per outer element a read and hold,
//   then a check and compare per comparison, plus a check when the walk runs off the bottom.
// Drain: sorted results, each held valid until res_ready; item_ready stays low until done.
// Async reset clears the sequencer, counts and output valid; RAM contents are not reset.
module shell_sort_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  ssort_pkg::ssort_in_t  item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ssort_pkg::ssort_out_t res
);
	import ssort_pkg::*;

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_GAP  = 4'd1;
	localparam logic [3:0] ST_RDH  = 4'd2;
	localparam logic [3:0] ST_HLD  = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_CMP  = 4'd5;
	localparam logic [3:0] ST_ORD  = 4'd6;
	localparam logic [3:0] ST_OLD  = 4'd7;
	localparam logic [3:0] ST_OWT  = 4'd8;

	logic [3:0]               state_q;
	logic [CNT_W-1:0]         count_q;
	logic [GAP_SEL_W-1:0]     gi_q;
	logic [CNT_W-1:0]         outer_q;
	logic [CNT_W-1:0]         inner_q;
	logic [CNT_W-1:0]         k_q;
	logic signed [VAL_W-1:0]  held_q;
	logic [TALLY_W-1:0]       cmp_q;
	logic [TALLY_W-1:0]       shf_q;
	logic                     res_valid_q;
	ssort_out_t               res_q;

	logic                     we;
	logic [IDX_W-1:0]         wa;
	logic [VAL_W-1:0]         wd;
	logic [IDX_W-1:0]         ra;
	logic [VAL_W-1:0]         rd;

	logic [GAP_W-1:0]         gap;
	logic [GAP_W-1:0]         inner_ext;
	logic [GAP_W-1:0]         below_idx;
	logic                     inner_ge_gap;
	logic                     below_gt;
	logic [CNT_W-1:0]         outer_nx;
	logic                     item_xfer;
	logic                     has_room;

	assign item_ready   = (state_q == ST_LOAD);
	assign item_xfer    = item_valid && item_ready;
	assign has_room     = (count_q < CNT_W'(DEPTH));
	assign gap          = gap_at(gi_q[GAP_SEL_W-2:0]);
	assign inner_ext    = {{(GAP_W-CNT_W){1'b0}}, inner_q};
	assign inner_ge_gap = (inner_ext >= gap);
	assign below_idx    = inner_ext - gap;
	assign below_gt     = ($signed(rd) > held_q);
	assign outer_nx     = outer_q + 1'b1;

	always_comb begin
		we = 1'b0;
		wa = inner_q[IDX_W-1:0];
		wd = held_q;
		ra = outer_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				we = item_xfer && has_room;
				wa = count_q[IDX_W-1:0];
				wd = item.value;
			end
			ST_CHK: begin
				ra = below_idx[IDX_W-1:0];
				we = !inner_ge_gap;
			end
			ST_CMP: begin
				we = 1'b1;
				wd = below_gt ? rd : held_q;
			end
			ST_ORD: begin
				ra = k_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	ssort_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (we),
		.wr_addr (wa),
		.wr_data (wd),
		.rd_addr (ra),
		.rd_data (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			gi_q        <= '0;
			outer_q     <= '0;
			inner_q     <= '0;
			k_q         <= '0;
			held_q      <= '0;
			cmp_q       <= '0;
			shf_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_xfer) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
						end
						if (item.last) begin
							gi_q    <= '0;
							cmp_q   <= '0;
							shf_q   <= '0;
							state_q <= ST_GAP;
						end
					end
				end
				ST_GAP: begin
					if (gi_q == GAP_SEL_W'(GAP_COUNT)) begin
						k_q     <= '0;
						state_q <= ST_ORD;
					end else if (gap >= {{(GAP_W-CNT_W){1'b0}}, count_q}) begin
						gi_q <= gi_q + 1'b1;
					end else begin
						outer_q <= gap[CNT_W-1:0];
						state_q <= ST_RDH;
					end
				end
				ST_RDH: begin
					state_q <= ST_HLD;
				end
				ST_HLD: begin
					held_q  <= rd;
					inner_q <= outer_q;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (inner_ge_gap) begin
						state_q <= ST_CMP;
					end else begin
						// held value lands at inner; move on to next outer
						outer_q <= outer_nx;
						if (outer_nx < count_q) begin
							state_q <= ST_RDH;
						end else begin
							gi_q    <= gi_q + 1'b1;
							state_q <= ST_GAP;
						end
					end
				end
				ST_CMP: begin
					cmp_q <= sat_inc(cmp_q);
					if (below_gt) begin
						shf_q   <= sat_inc(shf_q);
						inner_q <= below_idx[CNT_W-1:0];
						state_q <= ST_CHK;
					end else begin
						outer_q <= outer_nx;
						if (outer_nx < count_q) begin
							state_q <= ST_RDH;
						end else begin
							gi_q    <= gi_q + 1'b1;
							state_q <= ST_GAP;
						end
					end
				end
				ST_ORD: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_OWT;
				end
				ST_OWT: begin
					if (res_ready) begin
						res_valid_q <= 1'b0;
						if (k_q + 1'b1 == count_q) begin
							count_q <= '0;
							cmp_q   <= '0;
							shf_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OLD) begin
			res_q.sorted_value  <= rd;
			res_q.final_res     <= (k_q + 1'b1 == count_q);
			res_q.compare_count <= cmp_q;
			res_q.shift_count   <= shf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
